### src/wsp_pkg.sv
package wsp_pkg;

  localparam int CLIP_W     = 50;
  localparam int NUM_W      = 51;
  localparam int DEN_W      = 50;
  localparam int SCALE_W    = 15;
  localparam int COORD_W    = 32;
  localparam int DIV_STEPS  = 32;
  localparam int PIPE_DEPTH = 39;

  typedef enum logic [2:0] {
    REG_CLIP_X   = 3'd0,
    REG_CLIP_Y   = 3'd1,
    REG_CLIP_W   = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               visible;
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
  } res_t;

endpackage

### src/wsp_point_if.sv
interface wsp_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] world_x;
  logic [31:0] world_y;
  logic [31:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

### src/wsp_screen_if.sv
interface wsp_screen_if;
  logic        valid;
  logic        ready;
  logic        visible;
  logic [31:0] screen_x;
  logic [31:0] screen_y;

  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

### src/world_to_screen_projection_unit.sv
// throughput: one point per cycle, stalling while the two-word output queue is full
// 39 register stages lie ahead of that output queue
// the divider is a 32-step restoring array, one quotient bit per stage
// rst is synchronous: clears valid bits and queue, loads coefficients 0 and
// viewport 1920 x 1080
module world_to_screen_projection_unit
  import wsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [63:0]   wr_data,
  wsp_point_if.sink     point,
  wsp_screen_if.source  screen
);

  logic [63:0]        coef_x;
  logic [63:0]        coef_y;
  logic [63:0]        coef_w;
  logic [SCALE_W-1:0] scr_w;
  logic [SCALE_W-1:0] scr_h;

  logic                     en;
  logic [PIPE_DEPTH-1:0]    vld;
  logic [PIPE_DEPTH-3:0]    vis;
  logic signed [CLIP_W-1:0] cx;
  logic signed [CLIP_W-1:0] cy;
  logic signed [CLIP_W-1:0] cw;
  logic signed [NUM_W-1:0]  num_x;
  logic signed [NUM_W-1:0]  num_y;
  logic [DEN_W-1:0]         den;
  logic [COORD_W-1:0]       qx;
  logic [COORD_W-1:0]       qy;

  res_t       mem [2];
  res_t       res;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x <= '0;
      coef_y <= '0;
      coef_w <= '0;
      scr_w  <= SCALE_W'(1920);
      scr_h  <= SCALE_W'(1080);
    end else if (wr_en) begin
      case (wr_index)
        REG_CLIP_X: coef_x <= wr_data;
        REG_CLIP_Y: coef_y <= wr_data;
        REG_CLIP_W: coef_w <= wr_data;
        REG_WIDTH:  scr_w  <= wr_data[SCALE_W-1:0];
        REG_HEIGHT: scr_h  <= wr_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = (count != 2'd2);
  assign point.ready = en;

  wsp_clip u_clip (
    .clk    (clk),
    .en     (en),
    .x      (point.world_x),
    .y      (point.world_y),
    .z      (point.world_z),
    .coef_x (coef_x),
    .coef_y (coef_y),
    .coef_w (coef_w),
    .cx     (cx),
    .cy     (cy),
    .cw     (cw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], point.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= NUM_W'(cx) + NUM_W'(cw);
      num_y <= NUM_W'(cw) - NUM_W'(cy);
      den   <= {cw[DEN_W-2:0], 1'b0};
      vis   <= {vis[PIPE_DEPTH-4:0], (!cw[CLIP_W-1]) && (cw != '0)};
    end
  end

  wsp_div u_div_x (
    .clk   (clk),
    .en    (en),
    .num   (num_x),
    .den   (den),
    .scale (scr_w),
    .quo   (qx)
  );

  wsp_div u_div_y (
    .clk   (clk),
    .en    (en),
    .num   (num_y),
    .den   (den),
    .scale (scr_h),
    .quo   (qy)
  );

  assign res.visible  = vis[PIPE_DEPTH-3];
  assign res.screen_x = vis[PIPE_DEPTH-3] ? qx : '0;
  assign res.screen_y = vis[PIPE_DEPTH-3] ? qy : '0;

  // output queue
  assign push = en && vld[PIPE_DEPTH-1];
  assign pop  = screen.valid && screen.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign screen.valid    = (count != '0);
  assign screen.visible  = mem[rd_ptr].visible;
  assign screen.screen_x = mem[rd_ptr].screen_x;
  assign screen.screen_y = mem[rd_ptr].screen_y;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output queue count out of range");
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    screen.valid && !screen.visible |-> screen.screen_x == '0 && screen.screen_y == '0)
    else $error("hidden point with nonzero coordinates");
  a_reset_empty: assert property (@(posedge clk) rst |=> !screen.valid)
    else $error("output valid right after reset");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not grow on push");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |=> $stable(vld))
    else $error("pipeline moved while queue full");
`endif

endmodule

### src/wsp_clip.sv
module wsp_clip
  import wsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              x,
  input  logic [31:0]              y,
  input  logic [31:0]              z,
  input  logic [63:0]              coef_x,
  input  logic [63:0]              coef_y,
  input  logic [63:0]              coef_w,
  output logic signed [CLIP_W-1:0] cx,
  output logic signed [CLIP_W-1:0] cy,
  output logic signed [CLIP_W-1:0] cw
);

  logic [31:0]              pt   [3];
  logic [63:0]              coef [3];
  logic signed [47:0]       prod [3][3];
  logic signed [31:0]       cst  [3];
  logic signed [CLIP_W-1:0] clip [3];

  assign pt[0]   = x;
  assign pt[1]   = y;
  assign pt[2]   = z;
  assign coef[0] = coef_x;
  assign coef[1] = coef_y;
  assign coef[2] = coef_w;

  // stage 1: products, stage 2: sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= $signed(pt[k]) * $signed(coef[r][k*16 +: 16]);
        end
        cst[r]  <= $signed({coef[r][63:48], 16'b0});
        clip[r] <= CLIP_W'(prod[r][0]) + CLIP_W'(prod[r][1]) + CLIP_W'(prod[r][2])
                 + CLIP_W'(cst[r]);
      end
    end
  end

  assign cx = clip[0];
  assign cy = clip[1];
  assign cw = clip[2];

endmodule

### src/wsp_div.sv
module wsp_div
  import wsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  input  logic [SCALE_W-1:0]      scale,
  output logic [COORD_W-1:0]      quo
);

  logic [NUM_W-1:0]   a_abs;
  logic               a_neg;
  logic [DEN_W-1:0]   a_den;
  logic [39:0]        pp_hi;
  logic [39:0]        pp_lo;
  logic               b_neg;
  logic [DEN_W-1:0]   b_den;
  logic [64:0]        prod;
  logic [48:0]        hi;

  logic [DEN_W-1:0]   rem  [DIV_STEPS+1];
  logic [DEN_W-1:0]   dv   [DIV_STEPS+1];
  logic [31:0]        qv   [DIV_STEPS+1];
  logic [15:0]        lowb [DIV_STEPS+1];
  logic               ng   [DIV_STEPS+1];
  logic               st   [DIV_STEPS+1];
  logic [DEN_W:0]     trial [DIV_STEPS];
  logic               ge    [DIV_STEPS];

  logic [32:0]        lim;
  logic [31:0]        qc;

  assign a_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign hi    = prod[64:16];

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial[i] = {rem[i], lowb[i][15]};
      ge[i]    = trial[i] >= {1'b0, dv[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg <= num[NUM_W-1];
      a_den <= den;
      pp_hi <= a_abs[49:25] * scale;
      pp_lo <= a_abs[24:0] * scale;

      b_neg <= a_neg;
      b_den <= a_den;
      prod  <= {pp_hi, 25'b0} + 65'(pp_lo);

      rem[0]  <= DEN_W'(hi);
      dv[0]   <= b_den;
      qv[0]   <= '0;
      lowb[0] <= prod[15:0];
      ng[0]   <= b_neg;
      st[0]   <= {1'b0, hi} >= b_den;

      for (int i = 0; i < DIV_STEPS; i++) begin
        rem[i+1]  <= ge[i] ? DEN_W'(trial[i] - {1'b0, dv[i]}) : DEN_W'(trial[i]);
        qv[i+1]   <= {qv[i][30:0], ge[i]};
        lowb[i+1] <= {lowb[i][14:0], 1'b0};
        dv[i+1]   <= dv[i];
        ng[i+1]   <= ng[i];
        st[i+1]   <= st[i];
      end

      quo <= ng[DIV_STEPS] ? -qc : qc;
    end
  end

  always_comb begin
    lim = ng[DIV_STEPS] ? 33'h080000000 : 33'h07fffffff;
    if (st[DIV_STEPS] || ({1'b0, qv[DIV_STEPS]} > lim)) begin
      qc = lim[31:0];
    end else begin
      qc = qv[DIV_STEPS];
    end
  end

endmodule
